FILE: rtl/dsq_pkg.sv
`default_nettype none
package dsq_pkg;

  localparam int DsqDepth = 128;
  localparam int DsqDataW = 32;

  localparam int ValueW = 32;
  localparam int TotalW = 8;
  localparam int StatusW = 2;

  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  localparam logic [StatusW-1:0] ST_DONE  = 2'd0;
  localparam logic [StatusW-1:0] ST_DUP   = 2'd1;
  localparam logic [StatusW-1:0] ST_FULL  = 2'd2;
  localparam logic [StatusW-1:0] ST_EMPTY = 2'd3;

  // per-cell control, driven by the top level each cycle
  typedef struct packed {
    logic occ;    // cell holds a live entry
    logic load;   // write the enqueued value into this cell
    logic shift;  // take the neighbor's entry (dequeue)
  } cell_ctrl_t;

endpackage
`default_nettype wire

FILE: rtl/dsq_cell.sv
`default_nettype none
module dsq_cell #(
  parameter int DATA_W = dsq_pkg::DsqDataW
) (
  input  wire logic              clk,
  input  wire dsq_pkg::cell_ctrl_t ctrl,
  input  wire logic [DATA_W-1:0] load_val,
  input  wire logic [DATA_W-1:0] next_data,
  input  wire logic [DATA_W-1:0] cmp_val,
  output logic      [DATA_W-1:0] data_r,
  output logic                   hit_r
);
  import dsq_pkg::*;

  logic [DATA_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctrl.load) begin
      data_nxt = load_val;
    end else if (ctrl.shift) begin
      data_nxt = next_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    hit_r  <= ctrl.occ && (data_r == cmp_val);
  end

endmodule
`default_nettype wire

FILE: rtl/dedup_shift_queue_core.sv
`default_nettype none
// Queue of distinct values built as a row of DEPTH cells, entry 0 at the head.
// Each command goes through accept, a registered compare of the value
// against every live cell in parallel, then commit (append at the tail, or
// shift every cell one place toward the head on dequeue) with the result
// loaded into the output register. The next command is accepted while that
// result waits. A duplicate in a full queue reports duplicate. No clearing
// pass after reset: only cells below the entry count are ever compared or read.
module dedup_shift_queue_core #(
  parameter int DEPTH  = dsq_pkg::DsqDepth,
  parameter int DATA_W = dsq_pkg::DsqDataW
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // value[31:0]
  input  wire logic        in_tuser,   // command
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // removed_value[31:0], entry_total[39:32]
  output logic [1:0]       out_tuser   // status
);
  import dsq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_CMP    = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              cmd_r;
  logic [DATA_W-1:0] val_r;

  logic              out_valid_r, out_valid_nxt;
  logic [StatusW-1:0] out_status_r, out_status_nxt;
  logic [ValueW-1:0] out_removed_r, out_removed_nxt;
  logic [TotalW-1:0] out_total_r, out_total_nxt;

  logic [DATA_W-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]  hit;
  cell_ctrl_t        cell_ctrl [DEPTH];

  logic              slot_free, commit_go, any_hit, full, empty;
  logic              enq_ok, deq_ok;
  logic [63:0]       in_val_ext, head_ext;

  assign in_tready  = (state_r == S_IDLE);
  assign slot_free  = !out_valid_r || out_tready;
  assign commit_go  = (state_r == S_COMMIT) && slot_free;
  assign any_hit    = |hit;
  assign full       = (count_r == CNT_W'(DEPTH));
  assign empty      = (count_r == '0);
  assign enq_ok     = commit_go && (cmd_r == CMD_ENQ) && !any_hit && !full;
  assign deq_ok     = commit_go && (cmd_r == CMD_DEQ) && !empty;
  assign in_val_ext = {32'd0, in_tdata};
  assign head_ext   = 64'(cell_data[0]);

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      localparam logic [CNT_W-1:0] IDX = CNT_W'(g);
      logic [DATA_W-1:0] nbr;

      if (g == DEPTH - 1) begin : g_tail
        assign nbr = '0;
      end else begin : g_mid
        assign nbr = cell_data[g+1];
      end

      always_comb begin
        cell_ctrl[g].occ   = (IDX < count_r);
        cell_ctrl[g].load  = enq_ok && (count_r == IDX);
        cell_ctrl[g].shift = deq_ok;
      end

      dsq_cell #(.DATA_W(DATA_W)) u_cell (
        .clk      (clk),
        .ctrl     (cell_ctrl[g]),
        .load_val (val_r),
        .next_data(nbr),
        .cmp_val  (val_r),
        .data_r   (cell_data[g]),
        .hit_r    (hit[g])
      );
    end
  endgenerate

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_status_nxt  = out_status_r;
    out_removed_nxt = out_removed_r;
    out_total_nxt   = out_total_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (slot_free) begin
          state_nxt       = S_IDLE;
          out_valid_nxt   = 1'b1;
          out_removed_nxt = '0;
          out_status_nxt  = ST_DONE;
          if (cmd_r == CMD_ENQ) begin
            priority if (any_hit) begin
              out_status_nxt = ST_DUP;
            end else if (full) begin
              out_status_nxt = ST_FULL;
            end else begin
              count_nxt = count_r + 1'b1;
            end
          end else begin
            if (empty) begin
              out_status_nxt = ST_EMPTY;
            end else begin
              count_nxt       = count_r - 1'b1;
              out_removed_nxt = head_ext[ValueW-1:0];
            end
          end
          out_total_nxt = TotalW'(32'(count_nxt));
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // hold the command beat and the result payload
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cmd_r <= in_tuser;
      val_r <= in_val_ext[DATA_W-1:0];
    end
    out_status_r  <= out_status_nxt;
    out_removed_r <= out_removed_nxt;
    out_total_r   <= out_total_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {out_total_r, out_removed_r};

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COMMIT) |-> $onehot0(hit))
    else $error("value held in more than one cell");

  a_deq_count: assert property (@(posedge clk) disable iff (!rst_n)
    deq_ok |=> (count_r == CNT_W'($past(count_r) - 1'b1)))
    else $error("dequeue did not drop the count by one");

  a_enq_count: assert property (@(posedge clk) disable iff (!rst_n)
    enq_ok |=> (count_r == CNT_W'($past(count_r) + 1'b1)))
    else $error("enqueue did not raise the count by one");

endmodule
`default_nettype wire

FILE: dv/dsq_checker.sv
module dsq_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,    // value[31:0]
  input  logic        in_tuser,    // command
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,   // removed_value[31:0], entry_total[39:32]
  input  logic [1:0]  out_tuser,   // status
  output int          mismatches,
  output int          results_owed
);
  timeunit 1ns;
  timeprecision 1ps;
  import dsq_pkg::*;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [ValueW-1:0]  removed;
    logic [TotalW-1:0]  total;
  } queue_result_t;

  logic [DsqDataW-1:0] held_vals[$];   // entry 0 is the head
  queue_result_t       owed_results[$];
  int                  fail_total = 0;

  function automatic queue_result_t apply_command(logic cmd, logic [ValueW-1:0] value);
    queue_result_t       res;
    bit                  seen;
    logic [DsqDataW-1:0] stored;
    res    = '0;
    seen   = 1'b0;
    stored = DsqDataW'(value);
    res.status = ST_DONE;
    if (cmd == CMD_ENQ) begin
      foreach (held_vals[i]) begin
        if (held_vals[i] == stored) seen = 1'b1;
      end
      // duplicate takes priority over full
      if (seen) res.status = ST_DUP;
      else if (held_vals.size() >= DsqDepth) res.status = ST_FULL;
      else held_vals.push_back(stored);
    end else begin
      if (held_vals.size() == 0) res.status = ST_EMPTY;
      else res.removed = ValueW'(held_vals.pop_front());
    end
    res.total = TotalW'(held_vals.size());
    return res;
  endfunction

  always @(posedge clk) begin
    queue_result_t got;
    queue_result_t want;
    if (!rst_n) begin
      held_vals.delete();
      owed_results.delete();
    end else begin
      if (in_tvalid && in_tready) owed_results.push_back(apply_command(in_tuser, in_tdata));
      if (out_tvalid && out_tready) begin
        got.status  = out_tuser;
        got.removed = out_tdata[31:0];
        got.total   = out_tdata[39:32];
        if (owed_results.size() == 0) begin
          $error("unexpected result beat: status %0d removed_value %h entry_total %0d",
                 got.status, got.removed, got.total);
          fail_total++;
        end else begin
          want = owed_results.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_total++;
          end
          if (got.removed !== want.removed) begin
            $error("removed_value: expected %h, got %h", want.removed, got.removed);
            fail_total++;
          end
          if (got.total !== want.total) begin
            $error("entry_total: expected %0d, got %0d", want.total, got.total);
            fail_total++;
          end
        end
      end
    end
    mismatches   <= fail_total;
    results_owed <= owed_results.size();
  end

endmodule

FILE: dv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dsq_pkg::*;

  localparam int TargetItems = 700;
  localparam int QuietItems  = 60;
  localparam int HoldCycles  = 300;
  localparam int IdleLimit   = 2000;

  localparam logic [31:0] ExtremeVals[4] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic [31:0] in_tdata = '0;
  logic        in_tuser = CMD_ENQ;
  logic        out_tready = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;
  int          mismatches;
  int          results_owed;

  int          items_sent = 0;
  int          idle_cycles = 0;
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;
  bit          gappy = 1'b1;
  logic [31:0] recent_vals[$];

  always #1 clk = ~clk;

  dedup_shift_queue_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  dsq_checker queue_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .mismatches   (mismatches),
    .results_owed (results_owed)
  );

  // Offer one command and hold it until accepted; maybe drop valid for a gap after.
  task automatic issue(logic cmd, logic [31:0] value);
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= value;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if (cmd == CMD_ENQ) begin
      recent_vals.push_back(value);
      if (recent_vals.size() > 256) void'(recent_vals.pop_front());
    end
    if (!quiet && gappy && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= $urandom;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] recent_value(int span);
    int lim;
    lim = (recent_vals.size() < span) ? recent_vals.size() : span;
    if (lim == 0) return $urandom;
    return recent_vals[recent_vals.size() - 1 - $urandom_range(0, lim - 1)];
  endfunction

  function automatic logic [31:0] churn_value();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 7) return recent_value(32);
    if (pick < 11) return $urandom_range(0, 15);
    if (pick < 13) return ExtremeVals[$urandom_range(0, 3)];
    return $urandom;
  endfunction

  // Push past full, then probe with held values (duplicate) and fresh ones (full).
  task automatic fill_up();
    repeat (DsqDepth + 3) issue(CMD_ENQ, $urandom);
    repeat (8) issue(CMD_ENQ, $urandom_range(0, 1) ? recent_value(40) : $urandom);
  endtask

  task automatic drain();
    repeat ($urandom_range(10, DsqDepth + 4)) issue(CMD_DEQ, $urandom);
  endtask

  task automatic churn(int count);
    repeat (count) begin
      if ($urandom_range(0, 9) < 6) issue(CMD_ENQ, churn_value());
      else issue(CMD_DEQ, $urandom);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    issue(CMD_DEQ, 32'hFFFF_FFFF);
    issue(CMD_ENQ, 32'h8000_0000);
    issue(CMD_ENQ, 32'h7FFF_FFFF);
    issue(CMD_ENQ, 32'h0000_0000);
    issue(CMD_ENQ, 32'hFFFF_FFFF);
    issue(CMD_ENQ, 32'h7FFF_FFFF);
    issue(CMD_ENQ, 32'h0000_0000);
    issue(CMD_DEQ, 32'h0000_0000);
    issue(CMD_ENQ, 32'h8000_0000);
    issue(CMD_ENQ, 32'h5555_5555);
    issue(CMD_ENQ, 32'hAAAA_AAAA);
    repeat (6) issue(CMD_DEQ, 32'h5A5A_A5A5);
    issue(CMD_DEQ, 32'h0000_0000);

    // first random episode: gapless fill while the result side holds off
    hold_req = 1'b1;
    gappy    = 1'b0;
    fill_up();
    while (items_sent < TargetItems - QuietItems) begin
      gappy = ($urandom_range(0, 2) != 0);
      case ($urandom_range(0, 5))
        0: fill_up();
        1: drain();
        default: churn($urandom_range(20, 60));
      endcase
    end

    quiet = 1'b1;
    while (items_sent < TargetItems) churn(10);
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    wait (rst_n);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
      end else if (quiet || $urandom_range(0, 3) != 0) begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end else begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
    end
  end

  // Abort when neither channel moves a beat for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("tb_top: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

FILE: files.f
rtl/dsq_pkg.sv
rtl/dsq_cell.sv
rtl/dedup_shift_queue_core.sv
dv/dsq_checker.sv
dv/tb_top.sv
